FILE: rtl/core/codec_pll_rate_decode_macros.svh
// ----------------------------------------------------------------------------
// codec_pll_rate_decode_macros
// Assertion macros shared by the rate decoder RTL. They sample on clk and
// are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CODEC_PLL_RATE_DECODE_MACROS_SVH
`define CODEC_PLL_RATE_DECODE_MACROS_SVH

// Same-cycle implication.
`define CPRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cprd assertion failed");

// Next-cycle implication.
`define CPRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cprd assertion failed");

`endif

FILE: rtl/core/cprd_pkg.sv
// ----------------------------------------------------------------------------
// cprd_pkg
// Widths, codes and divider decode helpers for the codec PLL rate decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cprd_pkg;

    localparam int MCLK_W    = 27;
    localparam int BYTE_W    = 8;
    localparam int M_W       = 8;
    localparam int N_W       = 5;
    localparam int P_W       = 4;
    localparam int MN_W      = M_W + N_W;
    localparam int DIV_W     = 15;                  // M*N*P up to 16384
    localparam int PRE_SHIFT = 4;                   // the constant factor 16
    localparam int DVD_W     = MCLK_W - PRE_SHIFT;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam int M_FLAG_BIT = 7;

    localparam logic [M_W-1:0] M_RESET = M_W'(128);
    localparam logic [N_W-1:0] N_RESET = N_W'(16);
    localparam logic [P_W-1:0] P_RESET = P_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_MN,
        ST_MUL_P,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [M_W-1:0] decode_m(input logic [BYTE_W-1:0] b);
        logic [6:0] code;
        code = b[6:0];
        return (code == 7'd0) ? M_RESET : {1'b0, code};
    endfunction

    function automatic logic [N_W-1:0] decode_n(input logic [BYTE_W-1:0] b);
        logic [3:0] code;
        code = b[6:3];
        return (code == 4'd0) ? N_RESET : {1'b0, code};
    endfunction

    function automatic logic [P_W-1:0] decode_p(input logic [BYTE_W-1:0] b);
        logic [2:0] code;
        code = b[2:0];
        return (code == 3'd0) ? P_RESET : {1'b0, code};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cprd_divider.sv
// ----------------------------------------------------------------------------
// cprd_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cprd_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cprd_pkg::DVD_W-1:0] dividend,
    input  logic [cprd_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [cprd_pkg::DVD_W-1:0] quotient
);
    import cprd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVD_W-1:0]     quo_next;
    logic [DIV_W-1:0]     div_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // payload: dividend shifts out the top as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/core/codec_pll_rate_decode.sv
// Sequence from input accept to out_valid once both word kinds are seen:
// two multiply steps, 23 divider steps, output load; the divide is
// skipped when the rate is not yet valid. One item in flight: a new byte
// is taken only after the last result is loaded into the output register.
// Reset (rst_n, async low): held dividers 128/16/8, seen flags and master
// clock cleared, output empty.
// ----------------------------------------------------------------------------
// codec_pll_rate_decode
// Decodes codec clock-divider readback bytes into M, N, P and the sample
// rate master_clock_hz / (16*M*N*P).
// ----------------------------------------------------------------------------
`default_nettype none

`include "codec_pll_rate_decode_macros.svh"

module codec_pll_rate_decode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cprd_pkg::MCLK_W-1:0] master_clock_hz,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cprd_pkg::BYTE_W-1:0] reg_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cprd_pkg::MCLK_W-1:0] rate_hz,
    output logic                        rate_valid,
    output logic [cprd_pkg::M_W-1:0]    m_divider,
    output logic [cprd_pkg::N_W-1:0]    n_divider,
    output logic [cprd_pkg::P_W-1:0]    p_divider
);
    import cprd_pkg::*;

    state_t              state_reg;
    state_t              state_next;

    logic [MCLK_W-1:0]   mclk_reg;
    logic [M_W-1:0]      m_held_reg;
    logic [N_W-1:0]      n_held_reg;
    logic [P_W-1:0]      p_held_reg;
    logic                m_seen_reg;
    logic                pn_seen_reg;
    logic [MN_W-1:0]     mn_reg;
    logic [MN_W-1:0]     mn_prod;
    logic [DIV_W-1:0]    mnp_prod;

    logic                out_valid_reg;
    logic [MCLK_W-1:0]   rate_hz_reg;
    logic                rate_valid_reg;
    logic [M_W-1:0]      m_out_reg;
    logic [N_W-1:0]      n_out_reg;
    logic [P_W-1:0]      p_out_reg;

    logic                accept;
    logic                both_seen;
    logic                div_start;
    logic                div_done;
    logic [DVD_W-1:0]    div_quot;
    logic                out_load;

    assign both_seen = m_seen_reg && pn_seen_reg;
    assign mn_prod   = {{(MN_W-M_W){1'b0}}, m_held_reg} * {{(MN_W-N_W){1'b0}}, n_held_reg};
    assign mnp_prod  = {{(DIV_W-MN_W){1'b0}}, mn_reg} * {{(DIV_W-P_W){1'b0}}, p_held_reg};

    cprd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mclk_reg[MCLK_W-1:PRE_SHIFT]),
        .divisor  (mnp_prod),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        accept     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
                if (in_valid)
                begin
                    state_next = ST_MUL_MN;
                end
            end
            ST_MUL_MN:
            begin
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                // skip the divide while the rate is not valid
                if (both_seen)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mclk_reg      <= '0;
            m_held_reg    <= M_RESET;
            n_held_reg    <= N_RESET;
            p_held_reg    <= P_RESET;
            m_seen_reg    <= 1'b0;
            pn_seen_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mclk_reg <= master_clock_hz;
            end
            if (accept)
            begin
                if (reg_byte[M_FLAG_BIT])
                begin
                    m_held_reg <= decode_m(reg_byte);
                    m_seen_reg <= 1'b1;
                end
                else
                begin
                    n_held_reg  <= decode_n(reg_byte);
                    p_held_reg  <= decode_p(reg_byte);
                    pn_seen_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL_MN)
        begin
            mn_reg <= mn_prod;
        end
        if (out_load)
        begin
            rate_hz_reg    <= both_seen ? {{PRE_SHIFT{1'b0}}, div_quot} : '0;
            rate_valid_reg <= both_seen;
            m_out_reg      <= m_held_reg;
            n_out_reg      <= n_held_reg;
            p_out_reg      <= p_held_reg;
        end
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign rate_hz    = rate_hz_reg;
    assign rate_valid = rate_valid_reg;
    assign m_divider  = m_out_reg;
    assign n_divider  = n_out_reg;
    assign p_divider  = p_out_reg;

    `CPRD_ASSERT_NEXT(a_accept_to_mul, in_valid && !in_stall, state_reg == ST_MUL_MN)
    `CPRD_ASSERT_NOW(a_done_in_div, div_done, state_reg == ST_DIV)
    `CPRD_ASSERT_NOW(a_start_needs_seen, div_start, m_seen_reg && pn_seen_reg)
    `CPRD_ASSERT_NOW(a_invalid_rate_zero, out_valid && !rate_valid, rate_hz == '0)

endmodule

`default_nettype wire

FILE: test/codec_pll_rate_decode_chk.sv
// ----------------------------------------------------------------------------
// codec_pll_rate_decode_chk
// Watches the config, byte and result channels of the rate decoder. Keeps
// its own copy of the held dividers and the master clock, predicts one
// result per accepted byte and compares every accepted result, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module codec_pll_rate_decode_chk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [cprd_pkg::MCLK_W-1:0] master_clock_hz,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [cprd_pkg::BYTE_W-1:0] reg_byte,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [cprd_pkg::MCLK_W-1:0] rate_hz,
    input  logic                        rate_valid,
    input  logic [cprd_pkg::M_W-1:0]    m_divider,
    input  logic [cprd_pkg::N_W-1:0]    n_divider,
    input  logic [cprd_pkg::P_W-1:0]    p_divider,
    output int                          fail_count,
    output int                          rates_outstanding,
    output int                          rates_checked
);
    import cprd_pkg::*;

    localparam int M_FULL        = 128;   // M code 0
    localparam int N_FULL        = 16;    // N code 0
    localparam int P_FULL        = 8;     // P code 0
    localparam int RATE_PRESCALE = 16;

    typedef struct packed {
        logic [MCLK_W-1:0] rate;
        logic              valid;
        logic [M_W-1:0]    m;
        logic [N_W-1:0]    n;
        logic [P_W-1:0]    p;
    } rate_result_t;

    rate_result_t      expected_rates[$];
    logic [MCLK_W-1:0] clk_hz_cfg;
    logic [M_W-1:0]    m_cur;
    logic [N_W-1:0]    n_cur;
    logic [P_W-1:0]    p_cur;
    logic              m_known;
    logic              pn_known;

    // Update the held dividers with one byte and work out the result it gives.
    function automatic rate_result_t decode_divider_byte(input logic [BYTE_W-1:0] b);
        rate_result_t r;
        logic [31:0]  divisor;
        if (b[M_FLAG_BIT])
        begin
            m_cur   = (b[6:0] == 7'd0) ? M_W'(M_FULL) : M_W'(b[6:0]);
            m_known = 1'b1;
        end
        else
        begin
            p_cur    = (b[2:0] == 3'd0) ? P_W'(P_FULL) : P_W'(b[2:0]);
            n_cur    = (b[6:3] == 4'd0) ? N_W'(N_FULL) : N_W'(b[6:3]);
            pn_known = 1'b1;
        end
        divisor = 32'(RATE_PRESCALE) * 32'(m_cur) * 32'(n_cur) * 32'(p_cur);
        r.valid = m_known && pn_known;
        r.rate  = r.valid ? MCLK_W'(32'(clk_hz_cfg) / divisor) : '0;
        r.m     = m_cur;
        r.n     = n_cur;
        r.p     = p_cur;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rate_result_t want;
        if (!rst_n)
        begin
            expected_rates.delete();
            clk_hz_cfg        = '0;
            m_cur             = M_W'(M_FULL);
            n_cur             = N_W'(N_FULL);
            p_cur             = P_W'(P_FULL);
            m_known           = 1'b0;
            pn_known          = 1'b0;
            fail_count        = 0;
            rates_checked     = 0;
            rates_outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rates.size() == 0)
                begin
                    $display("%0t: result with no byte outstanding, rate_hz %0d",
                             $time, rate_hz);
                    fail_count++;
                end
                else
                begin
                    want = expected_rates.pop_front();
                    check_field("rate_hz", 32'(want.rate), 32'(rate_hz));
                    check_field("rate_valid", 32'(want.valid), 32'(rate_valid));
                    check_field("m_divider", 32'(want.m), 32'(m_divider));
                    check_field("n_divider", 32'(want.n), 32'(n_divider));
                    check_field("p_divider", 32'(want.p), 32'(p_divider));
                    rates_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
                clk_hz_cfg = master_clock_hz;
            if (in_valid && !in_stall)
                expected_rates.push_back(decode_divider_byte(reg_byte));
            rates_outstanding = expected_rates.size();
        end
    end

endmodule

FILE: test/codec_pll_rate_decode_tb.sv
// ----------------------------------------------------------------------------
// codec_pll_rate_decode_tb
// Drives divider readback bytes and master clock settings into the rate
// decoder: a directed set of zero codes and divider extremes, then random
// bytes under several clock settings with idle and stall on both channels,
// two long result hold-offs and drains between settings. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module codec_pll_rate_decode_tb;

    import cprd_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_BYTES   = 200;
    localparam int DRAIN_CYCLES  = 40;
    localparam logic [MCLK_W-1:0] MCLK_TOP     = MCLK_W'(100000000);
    localparam logic [MCLK_W-1:0] MCLK_ALL_ONE = '1;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [MCLK_W-1:0] master_clock_hz;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] reg_byte;
    logic              out_valid;
    logic              out_stall;
    logic [MCLK_W-1:0] rate_hz;
    logic              rate_valid;
    logic [M_W-1:0]    m_divider;
    logic [N_W-1:0]    n_divider;
    logic [P_W-1:0]    p_divider;

    int fail_count;
    int rates_outstanding;
    int rates_checked;

    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 57;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;
    int          bytes_sent    = 0;
    int          clock_loads   = 0;

    codec_pll_rate_decode u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .master_clock_hz (master_clock_hz),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .reg_byte        (reg_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rate_hz         (rate_hz),
        .rate_valid      (rate_valid),
        .m_divider       (m_divider),
        .n_divider       (n_divider),
        .p_divider       (p_divider)
    );

    codec_pll_rate_decode_chk u_chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .master_clock_hz   (master_clock_hz),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .reg_byte          (reg_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .rate_hz           (rate_hz),
        .rate_valid        (rate_valid),
        .m_divider         (m_divider),
        .n_divider         (n_divider),
        .p_divider         (p_divider),
        .fail_count        (fail_count),
        .rates_outstanding (rates_outstanding),
        .rates_checked     (rates_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("codec_pll_rate_decode test failed");
        $finish;
    end

    // Result side: random stall, or a long hold-off when one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        reg_byte <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (rates_outstanding == 0);
    endtask

    task automatic load_master_clock(input logic [MCLK_W-1:0] hz);
        @(negedge clk);
        cfg_valid       <= 1'b1;
        master_clock_hz <= hz;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        clock_loads++;
    endtask

    // Mostly uniform bytes, with zero codes and divider extremes mixed in.
    function automatic logic [BYTE_W-1:0] pick_divider_byte();
        case ($urandom_range(15))
            0:       return 8'h80;
            1:       return 8'h00;
            2:       return 8'h81;
            3:       return 8'h09;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        logic [MCLK_W-1:0] clock_plan[PHASES];
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        master_clock_hz = '0;
        in_valid        = 1'b0;
        reg_byte        = '0;
        clock_plan[0]   = MCLK_W'(1);
        clock_plan[1]   = MCLK_W'(12288000);
        clock_plan[2]   = MCLK_W'(24576000);
        clock_plan[3]   = MCLK_TOP;
        clock_plan[4]   = MCLK_ALL_ONE;
        clock_plan[5]   = MCLK_W'($urandom_range(MCLK_ALL_ONE));
        clock_plan[6]   = MCLK_W'(11289600);
        clock_plan[7]   = MCLK_W'($urandom_range(MCLK_ALL_ONE));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // M alone is not enough for a rate; then zero codes and extremes.
        load_master_clock(MCLK_TOP);
        push_byte(8'h80);
        push_byte(8'h00);
        push_byte(8'h81);
        push_byte(8'h09);
        push_byte(8'hFF);
        push_byte(8'h7F);
        push_byte(8'h01);
        push_byte(8'h08);
        push_byte(8'hC0);
        push_byte(8'h40);
        push_byte(8'hAA);
        push_byte(8'h55);
        push_byte(8'h87);
        push_byte(8'h38);
        drain_results();
        load_master_clock(MCLK_ALL_ONE);
        push_byte(8'h81);
        push_byte(8'h09);
        push_byte(8'h80);
        push_byte(8'h00);
        drain_results();
        load_master_clock('0);
        push_byte(8'h92);
        push_byte(8'h23);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 57;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_results();
            load_master_clock(clock_plan[ph]);
            // Keep offering bytes while results are held off.
            if (ph == 1 || ph == 6)
                hold_req = 1'b1;
            repeat (PHASE_BYTES) push_byte(pick_divider_byte());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d divider bytes under %0d master clock settings, %0d results checked,",
                 bytes_sent, clock_loads, rates_checked);
        $display("with idle and stall on both sides and two long result hold-offs.");
        if (fail_count == 0)
            $display("codec_pll_rate_decode test passed");
        else
            $display("codec_pll_rate_decode test failed");
        $finish;
    end

endmodule
